// ===== rtl/plbm_pkg.sv =====
// plbm_pkg: shared types and constants for the price level book matcher
// holds the level word layout and the transaction field codes
// no dependencies
package plbm_pkg;

    localparam int PRICE_W     = 32;
    localparam int QTY_W       = 32;
    localparam int FRAC_W      = 8;
    localparam int INT_W       = PRICE_W - FRAC_W;
    localparam int LEVEL_OUT_W = 6;
    localparam int SEQ_W       = 32;

    // transaction kind codes
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    // order side codes
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // one price level as stored in a table
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } level_t;

endpackage

// ===== rtl/price_level_book_matcher.sv =====
// price_level_book_matcher: two tables of price levels with a sequenced matcher
// uses plbm_pkg for the level word layout and field codes
// Usage
//   s_ channel: one transaction per item. kind add writes the level chosen by
//   the integer price modulo LEVEL_COUNT on the bid or ask side; kind match
//   scans both tables and produces one result transaction on the m_ channel.
//   Adds produce no result.
// Timing
//   add:   ready again after states S_MUL, S_REM, S_ARD and S_AWR (multiply by
//          the reciprocal of LEVEL_COUNT, multiply back and subtract for the
//          remainder, then one read and one write of the level table)
//   match: result registered after states S_SCAN, S_SLAST, S_TRADE, S_WB and
//          S_OUT; the scan reads one level of each table per cycle through a
//          single read port; no new item is taken until the result is registered
// Reset
//   aresetn low starts a clearing pass that zeroes every level of both tables;
//   s_ready stays low until it ends.
// Stall
//   the result sits in an output register; a new item is still taken while it
//   waits, but a following match holds its result until m_ready frees the slot.
module price_level_book_matcher #(
    parameter int LEVEL_COUNT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic                                s_side,
    input  logic [plbm_pkg::PRICE_W-1:0]        s_price,
    input  logic [plbm_pkg::QTY_W-1:0]          s_quantity,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_traded,
    output logic [plbm_pkg::PRICE_W-1:0]        m_trade_price,
    output logic [plbm_pkg::QTY_W-1:0]          m_trade_quantity,
    output logic [plbm_pkg::LEVEL_OUT_W-1:0]    m_bid_level,
    output logic [plbm_pkg::LEVEL_OUT_W-1:0]    m_ask_level,
    output logic [plbm_pkg::SEQ_W-1:0]          m_sequence_res
);

    localparam int IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LEVEL_COUNT - 1);
    localparam logic [IDX_W-1:0] LEVELS_LO = IDX_W'(LEVEL_COUNT);

    // reciprocal of LEVEL_COUNT, exact quotient for every integer price
    localparam int REM_SH  = plbm_pkg::INT_W + IDX_W;
    localparam int RECIP_W = plbm_pkg::INT_W + 2;
    localparam int PROD_W  = plbm_pkg::INT_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << REM_SH) + 64'(LEVEL_COUNT) - 64'd1) / 64'(LEVEL_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_REM   = 4'd3;
    localparam logic [3:0] S_ARD   = 4'd4;
    localparam logic [3:0] S_AWR   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_SLAST = 4'd7;
    localparam logic [3:0] S_TRADE = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg;

    // level tables
    plbm_pkg::level_t bid_mem [LEVEL_COUNT];
    plbm_pkg::level_t ask_mem [LEVEL_COUNT];
    plbm_pkg::level_t bid_rd_reg, ask_rd_reg;
    plbm_pkg::level_t bid_wdata, ask_wdata;
    logic             bid_we, ask_we;
    logic [IDX_W-1:0] bid_waddr, ask_waddr, rd_addr;

    // captured add transaction
    logic                          side_reg;
    logic [plbm_pkg::PRICE_W-1:0]  price_reg;
    logic [plbm_pkg::QTY_W-1:0]    qty_reg;

    // remainder unit
    logic [PROD_W-1:0]              prod_reg;
    logic [IDX_W-1:0]               quo_lo;
    logic [IDX_W-1:0]               rem_reg;
    logic [IDX_W-1:0]               rem_next;

    // scan tracking
    logic                          pend_reg;
    logic [IDX_W-1:0]              pidx_reg;
    logic                          bok_reg, aok_reg;
    logic [plbm_pkg::PRICE_W-1:0]  bbest_reg, abest_reg;
    logic [plbm_pkg::QTY_W-1:0]    bqty_reg, aqty_reg;
    logic [IDX_W-1:0]              bidx_reg, aidx_reg;
    logic                          bid_take, ask_take;

    // trade results
    logic                          cross_reg;
    logic [plbm_pkg::QTY_W-1:0]    tq_reg;
    logic [plbm_pkg::PRICE_W-1:0]  mid_reg;
    logic [plbm_pkg::PRICE_W:0]    mid_sum;
    logic [plbm_pkg::SEQ_W-1:0]    count_reg;

    // add path
    plbm_pkg::level_t              add_old;
    logic [plbm_pkg::QTY_W:0]      add_sum;
    logic [plbm_pkg::QTY_W-1:0]    add_qty;

    // output register
    logic                             m_valid_reg;
    logic                             m_traded_reg;
    logic [plbm_pkg::PRICE_W-1:0]     m_price_reg;
    logic [plbm_pkg::QTY_W-1:0]       m_qty_reg;
    logic [plbm_pkg::LEVEL_OUT_W-1:0] m_bid_lvl_reg, m_ask_lvl_reg;
    logic [plbm_pkg::SEQ_W-1:0]       m_seq_reg;

    logic s_fire;
    logic out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // remainder: integer price minus quotient times LEVEL_COUNT, low bits only
    assign quo_lo   = prod_reg[REM_SH +: IDX_W];
    assign rem_next = price_reg[plbm_pkg::FRAC_W +: IDX_W] - quo_lo * LEVELS_LO;

    // saturating quantity add
    assign add_old = (side_reg == plbm_pkg::SIDE_ASK) ? ask_rd_reg : bid_rd_reg;
    assign add_sum = {1'b0, add_old.quantity} + {1'b0, qty_reg};
    assign add_qty = add_sum[plbm_pkg::QTY_W] ? '1 : add_sum[plbm_pkg::QTY_W-1:0];

    // scan compare on the level read in the previous cycle
    assign bid_take = pend_reg && (bid_rd_reg.quantity != '0) &&
                      (!bok_reg || (bid_rd_reg.price > bbest_reg));
    assign ask_take = pend_reg && (ask_rd_reg.quantity != '0) &&
                      (!aok_reg || (ask_rd_reg.price < abest_reg));

    assign mid_sum = {1'b0, bbest_reg} + {1'b0, abest_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (cnt_reg == LAST_IDX) state_next = S_IDLE;
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_kind == plbm_pkg::KIND_MATCH) ? S_SCAN : S_MUL;
                end
            end
            S_MUL:   state_next = S_REM;
            S_REM:   state_next = S_ARD;
            S_ARD:   state_next = S_AWR;
            S_AWR:   state_next = S_IDLE;
            S_SCAN:  if (cnt_reg == LAST_IDX) state_next = S_SLAST;
            S_SLAST: state_next = S_TRADE;
            S_TRADE: state_next = S_WB;
            S_WB:    state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // table write and read port control
    always_comb begin
        bid_we    = 1'b0;
        ask_we    = 1'b0;
        bid_waddr = cnt_reg;
        ask_waddr = cnt_reg;
        bid_wdata = '0;
        ask_wdata = '0;
        rd_addr   = (state_reg == S_SCAN) ? cnt_reg : rem_reg;
        case (state_reg)
            S_CLEAR: begin
                bid_we = 1'b1;
                ask_we = 1'b1;
            end
            S_AWR: begin
                bid_we    = (side_reg == plbm_pkg::SIDE_BID);
                ask_we    = (side_reg == plbm_pkg::SIDE_ASK);
                bid_waddr = rem_reg;
                ask_waddr = rem_reg;
                bid_wdata = '{price: price_reg, quantity: add_qty};
                ask_wdata = '{price: price_reg, quantity: add_qty};
            end
            S_WB: begin
                bid_we    = cross_reg;
                ask_we    = cross_reg;
                bid_waddr = bidx_reg;
                ask_waddr = aidx_reg;
                bid_wdata = '{price: bbest_reg, quantity: bqty_reg - tq_reg};
                ask_wdata = '{price: abest_reg, quantity: aqty_reg - tq_reg};
            end
            default: begin
                bid_we = 1'b0;
            end
        endcase
    end

    // level tables, registered read
    always_ff @(posedge aclk) begin
        if (bid_we) bid_mem[bid_waddr] <= bid_wdata;
        if (ask_we) ask_mem[ask_waddr] <= ask_wdata;
        bid_rd_reg <= bid_mem[rd_addr];
        ask_rd_reg <= ask_mem[rd_addr];
    end

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            bok_reg     <= 1'b0;
            aok_reg     <= 1'b0;
            cross_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_SCAN);

            // level counter for clearing and scanning
            if (state_reg == S_CLEAR || state_reg == S_SCAN) begin
                cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            end

            if (s_fire && s_kind == plbm_pkg::KIND_MATCH) begin
                cnt_reg <= '0;
                bok_reg <= 1'b0;
                aok_reg <= 1'b0;
            end
            if (bid_take) bok_reg <= 1'b1;
            if (ask_take) aok_reg <= 1'b1;

            if (state_reg == S_TRADE) begin
                cross_reg <= bok_reg && aok_reg && (bbest_reg >= abest_reg);
            end

            // change counter
            if (state_reg == S_AWR || (state_reg == S_WB && cross_reg)) begin
                count_reg <= count_reg + 1'b1;
            end

            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == S_OUT && out_free) m_valid_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            side_reg  <= s_side;
            price_reg <= s_price;
            qty_reg   <= s_quantity;
        end

        // level index: reciprocal multiply, then multiply back and subtract
        if (state_reg == S_MUL) begin
            prod_reg <= PROD_W'(price_reg[plbm_pkg::PRICE_W-1:plbm_pkg::FRAC_W]) *
                        PROD_W'(RECIP);
        end
        if (state_reg == S_REM) begin
            rem_reg <= rem_next;
        end

        pidx_reg <= cnt_reg;

        // best bid and best ask so far
        if (bid_take) begin
            bbest_reg <= bid_rd_reg.price;
            bqty_reg  <= bid_rd_reg.quantity;
            bidx_reg  <= pidx_reg;
        end
        if (ask_take) begin
            abest_reg <= ask_rd_reg.price;
            aqty_reg  <= ask_rd_reg.quantity;
            aidx_reg  <= pidx_reg;
        end

        if (state_reg == S_TRADE) begin
            tq_reg <= (bqty_reg < aqty_reg) ? bqty_reg : aqty_reg;
        end
        if (state_reg == S_WB) begin
            mid_reg <= mid_sum[plbm_pkg::PRICE_W:1];
        end

        // result transaction
        if (state_reg == S_OUT && out_free) begin
            m_traded_reg  <= cross_reg;
            m_price_reg   <= cross_reg ? mid_reg : '0;
            m_qty_reg     <= cross_reg ? tq_reg : '0;
            m_bid_lvl_reg <= cross_reg ? plbm_pkg::LEVEL_OUT_W'(bidx_reg) : '0;
            m_ask_lvl_reg <= cross_reg ? plbm_pkg::LEVEL_OUT_W'(aidx_reg) : '0;
            m_seq_reg     <= count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_traded         = m_traded_reg;
    assign m_trade_price    = m_price_reg;
    assign m_trade_quantity = m_qty_reg;
    assign m_bid_level      = m_bid_lvl_reg;
    assign m_ask_level      = m_ask_lvl_reg;
    assign m_sequence_res   = m_seq_reg;

endmodule

// ===== rtl/plbm_checker.sv =====
// plbm_checker: port level checks for the price level book matcher
// uses plbm_pkg for field widths and codes; bound to the top level below
module plbm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_kind,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_traded,
    input logic [plbm_pkg::PRICE_W-1:0]        m_trade_price,
    input logic [plbm_pkg::QTY_W-1:0]          m_trade_quantity,
    input logic [plbm_pkg::LEVEL_OUT_W-1:0]    m_bid_level,
    input logic [plbm_pkg::LEVEL_OUT_W-1:0]    m_ask_level,
    input logic [plbm_pkg::SEQ_W-1:0]          m_sequence_res
);

    // stalled result stays valid and holds its price, quantity, sequence and traded flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_trade_price) &&
        $stable(m_trade_quantity) && $stable(m_sequence_res) && $stable(m_traded))
        else $error("result changed while stalled");

    // reset starts the clearing pass with nothing in flight
    assert property (@(posedge aclk) !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    // a match transaction keeps the block busy through its scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == plbm_pkg::KIND_MATCH |=> !s_ready)
        else $error("input taken during scan");

    // no trade means all trade fields are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_traded |-> m_trade_price == '0 && m_trade_quantity == '0 &&
        m_bid_level == '0 && m_ask_level == '0)
        else $error("nonzero fields without a trade");

    // a trade always moves a live quantity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_traded |-> m_trade_quantity != '0)
        else $error("trade with zero quantity");

endmodule

bind price_level_book_matcher plbm_checker u_plbm_checker (.*);
